[rtl/core/cmcd_pkg.sv]
// Shared types, constants and the pattern lookup for the color mark command decoder.
// No dependencies; used by every module in rtl/core.
package cmcd_pkg;

	localparam int COLOR_W = 3;
	localparam int RUN_W = 8;
	localparam int CMD_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MARK_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WHITE_CODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLACK_CODE = 2'd2;

	// Reset values of the registers
	localparam logic [RUN_W-1:0] THRESHOLD_RESET = 8'd10;
	localparam logic [COLOR_W-1:0] WHITE_RESET = 3'd0;
	localparam logic [COLOR_W-1:0] BLACK_RESET = 3'd1;
	localparam logic [RUN_W-1:0] RUN_MAX = 8'hFF;

	// Mark colors
	localparam logic [COLOR_W-1:0] COLOR_RED = 3'd3;
	localparam logic [COLOR_W-1:0] COLOR_GREEN = 3'd4;
	localparam logic [COLOR_W-1:0] COLOR_BLUE = 3'd5;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_NONE = 4'd0;
	localparam logic [CMD_W-1:0] CMD_VERY_SLOW = 4'd1;
	localparam logic [CMD_W-1:0] CMD_SLOW = 4'd2;
	localparam logic [CMD_W-1:0] CMD_NORMAL = 4'd3;
	localparam logic [CMD_W-1:0] CMD_FAST = 4'd4;
	localparam logic [CMD_W-1:0] CMD_VERY_FAST = 4'd5;
	localparam logic [CMD_W-1:0] CMD_PAUSE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_LEFT = 4'd7;
	localparam logic [CMD_W-1:0] CMD_FORWARD = 4'd8;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 4'd9;
	localparam logic [CMD_W-1:0] CMD_UTURN = 4'd10;
	localparam logic [CMD_W-1:0] CMD_GO_BACK = 4'd11;

	typedef struct packed {
		logic [RUN_W-1:0]   mark_threshold;
		logic [COLOR_W-1:0] white_code;
		logic [COLOR_W-1:0] black_code;
	} cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic               sequence_end;
		logic [COLOR_W-1:0] stable_mark;
	} result_t;

	typedef struct packed {
		logic [COLOR_W-1:0] first;
		logic [COLOR_W-1:0] second;
		logic [COLOR_W-1:0] third;
	} marks_t;

	// Map the first three marks of a sequence to a command
	function automatic logic [CMD_W-1:0] pattern_lookup(input marks_t m);
		logic [CMD_W-1:0] cmd;
		cmd = CMD_NONE;
		case (m)
			{COLOR_GREEN, COLOR_RED, COLOR_BLUE}:   cmd = CMD_VERY_SLOW;
			{COLOR_RED, COLOR_GREEN, COLOR_BLUE}:   cmd = CMD_SLOW;
			{COLOR_RED, COLOR_GREEN, COLOR_RED}:    cmd = CMD_NORMAL;
			{COLOR_BLUE, COLOR_GREEN, COLOR_RED}:   cmd = CMD_FAST;
			{COLOR_BLUE, COLOR_RED, COLOR_GREEN}:   cmd = CMD_VERY_FAST;
			{COLOR_BLUE, COLOR_RED, COLOR_BLUE}:    cmd = CMD_PAUSE;
			{COLOR_GREEN, COLOR_BLUE, COLOR_RED}:   cmd = CMD_LEFT;
			{COLOR_BLUE, COLOR_GREEN, COLOR_BLUE}:  cmd = CMD_FORWARD;
			{COLOR_GREEN, COLOR_BLUE, COLOR_GREEN}: cmd = CMD_RIGHT;
			{COLOR_RED, COLOR_BLUE, COLOR_RED}:     cmd = CMD_UTURN;
			{COLOR_GREEN, COLOR_RED, COLOR_GREEN}:  cmd = CMD_GO_BACK;
			default:                                cmd = CMD_NONE;
		endcase
		return cmd;
	endfunction

endpackage

[rtl/core/color_mark_command_decoder_top.sv]
// Top level of the color mark command decoder: config registers, handshakes, output register.
// Depends on cmcd_pkg and cmcd_mark_track.
// One color sample goes in per word and exactly one result word comes out in the cycle
// after the sample is accepted. A new sample is accepted every cycle as long as the
// output register is empty or is being drained in the same cycle, so the sustained rate
// is one sample per cycle; it is set by the single output register and the downstream
// ready. The result carries the command (nonzero only when a matched sequence closes),
// the sequence-end flag and the current debounced mark. Configuration registers are
// written directly through the write port and should only be changed while no word is
// in flight.
module color_mark_command_decoder_top #(
	parameter int SEQUENCE_WRAP = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [cmcd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cmcd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [cmcd_pkg::COLOR_W-1:0]         color,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [cmcd_pkg::CMD_W-1:0]           command,
	output logic                                 sequence_end,
	output logic [cmcd_pkg::COLOR_W-1:0]         stable_mark
);

	cmcd_pkg::cfg_t    cfg_q;
	cmcd_pkg::result_t result;
	cmcd_pkg::result_t result_q;
	logic              out_valid_q;
	logic              in_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mark_threshold <= cmcd_pkg::THRESHOLD_RESET;
			cfg_q.white_code <= cmcd_pkg::WHITE_RESET;
			cfg_q.black_code <= cmcd_pkg::BLACK_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cmcd_pkg::CFG_MARK_THRESHOLD: cfg_q.mark_threshold <= cfg_data;
				cmcd_pkg::CFG_WHITE_CODE: cfg_q.white_code <= cfg_data[cmcd_pkg::COLOR_W-1:0];
				cmcd_pkg::CFG_BLACK_CODE: cfg_q.black_code <= cfg_data[cmcd_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Input handshake: take a word whenever the output slot frees up
	assign in_ready = !out_valid_q || out_ready;
	assign in_take = in_valid && in_ready;

	cmcd_mark_track #(
		.SEQUENCE_WRAP (SEQUENCE_WRAP)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (in_take),
		.color   (color),
		.cfg     (cfg_q),
		.result  (result)
	);

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign command = result_q.command;
	assign sequence_end = result_q.sequence_end;
	assign stable_mark = result_q.stable_mark;

endmodule

[rtl/core/cmcd_pattern_match.sv]
// Pattern matcher: turns the three stored marks into a command code.
// Depends on cmcd_pkg.
module cmcd_pattern_match (
	input  cmcd_pkg::marks_t                 marks,
	output logic [cmcd_pkg::CMD_W-1:0]       command
);

	// Table lookup, eleven patterns
	always_comb begin
		command = cmcd_pkg::pattern_lookup(marks);
	end

endmodule

[rtl/core/cmcd_mark_track.sv]
// Mark tracker: run counter, debounced mark, sequence counter and mark store.
// Depends on cmcd_pkg and cmcd_pattern_match.
module cmcd_mark_track #(
	parameter int SEQUENCE_WRAP = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [cmcd_pkg::COLOR_W-1:0]      color,
	input  cmcd_pkg::cfg_t                    cfg,
	output cmcd_pkg::result_t                 result
);

	localparam int LEN_W = $clog2(SEQUENCE_WRAP);
	localparam logic [LEN_W:0] WRAP_VAL = (LEN_W+1)'(SEQUENCE_WRAP);
	localparam logic [LEN_W-1:0] STORE_DEPTH = LEN_W'(3);

	logic [cmcd_pkg::COLOR_W-1:0] prev_color_q;
	logic [cmcd_pkg::RUN_W-1:0]   run_q;
	logic [cmcd_pkg::COLOR_W-1:0] last_mark_q;
	logic [LEN_W-1:0]             seq_len_q;
	cmcd_pkg::marks_t             store_q;

	logic [cmcd_pkg::RUN_W-1:0]   run_d;
	logic                         mark_hit;
	logic                         color_plain;
	logic                         last_plain;
	logic                         append;
	logic                         close;
	logic [LEN_W:0]               len_inc;
	logic [LEN_W-1:0]             seq_len_d;
	logic [cmcd_pkg::CMD_W-1:0]   match_cmd;

	// Run length, saturating
	always_comb begin
		if (color == prev_color_q) begin
			run_d = (run_q == cmcd_pkg::RUN_MAX) ? run_q : run_q + 1'b1;
		end else begin
			run_d = '0;
		end
	end

	// Mark change and sequence decisions
	always_comb begin
		mark_hit = (run_d > cfg.mark_threshold) && (color != last_mark_q);
		color_plain = (color == cfg.white_code) || (color == cfg.black_code);
		last_plain = (last_mark_q == cfg.white_code) || (last_mark_q == cfg.black_code);
		append = mark_hit && !color_plain;
		close = mark_hit && color_plain && !last_plain;
		len_inc = {1'b0, seq_len_q} + 1'b1;
		if (append) begin
			seq_len_d = (len_inc >= WRAP_VAL) ? '0 : len_inc[LEN_W-1:0];
		end else if (close) begin
			seq_len_d = '0;
		end else begin
			seq_len_d = seq_len_q;
		end
	end

	cmcd_pattern_match u_match (
		.marks   (store_q),
		.command (match_cmd)
	);

	// Result word for this sample
	always_comb begin
		result.command = (close && (seq_len_q >= STORE_DEPTH)) ? match_cmd : cmcd_pkg::CMD_NONE;
		result.sequence_end = close;
		result.stable_mark = mark_hit ? color : last_mark_q;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_color_q <= cmcd_pkg::WHITE_RESET;
			run_q <= '0;
			last_mark_q <= cmcd_pkg::WHITE_RESET;
			seq_len_q <= '0;
		end else if (advance) begin
			prev_color_q <= color;
			run_q <= run_d;
			if (mark_hit) begin
				last_mark_q <= color;
			end
			seq_len_q <= seq_len_d;
		end
	end

	// Mark store, first three positions only
	always_ff @(posedge clk) begin
		if (advance && append) begin
			case (seq_len_q)
				LEN_W'(0): store_q.first <= color;
				LEN_W'(1): store_q.second <= color;
				LEN_W'(2): store_q.third <= color;
				default: ;
			endcase
		end
	end

endmodule
